// File: src/group_of_k_reverser_top_macros.svh
// Assertion helpers for the group-of-k reverser.
`ifndef GROUP_OF_K_REVERSER_TOP_MACROS_SVH
`define GROUP_OF_K_REVERSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define GRK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expr must never be true outside reset
`define GRK_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GRK_ASSERT(lbl, clk, rst_n, prop, msg)
`define GRK_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: src/grk_pkg.sv
package grk_pkg;

    // width of the group size register
    localparam int GS_W = 5;
    // width of one sequence element
    localparam int VAL_W = 32;

    // how the back end must drain one finished group
    typedef struct packed {
        logic reverse;  // emit newest first
        logic last;     // final group of the sequence
    } grk_flags_t;

endpackage

// File: src/grk_queue.sv
`include "group_of_k_reverser_top_macros.svh"

// Two group buffers (ping-pong) plus one descriptor per buffer.
module grk_queue #(
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // front side
    output logic                          wr_free,
    input  logic                          wr_en,
    input  logic [IW-1:0]                 wr_idx,
    input  logic [grk_pkg::VAL_W-1:0]     wr_data,
    input  logic                          push,
    input  logic [CW-1:0]                 push_cnt,
    input  grk_pkg::grk_flags_t           push_flags,
    // back side
    output logic                          rd_valid,
    output logic [CW-1:0]                 rd_cnt,
    output grk_pkg::grk_flags_t           rd_flags,
    input  logic                          rd_en,
    input  logic [IW-1:0]                 rd_idx,
    output logic [grk_pkg::VAL_W-1:0]     rd_data,
    input  logic                          pop
);

    localparam int DEPTH = 2 * (2 ** IW);

    logic [grk_pkg::VAL_W-1:0] mem [DEPTH];
    logic [grk_pkg::VAL_W-1:0] rd_data_reg;

    logic                      wr_ptr_reg, wr_ptr_next;
    logic                      rd_ptr_reg, rd_ptr_next;
    logic [1:0]                full_reg, full_next;
    logic [CW-1:0]             cnt_reg [2];
    grk_pkg::grk_flags_t       flags_reg [2];

    assign wr_free  = !full_reg[wr_ptr_reg];
    assign rd_valid = full_reg[rd_ptr_reg];
    assign rd_cnt   = cnt_reg[rd_ptr_reg];
    assign rd_flags = flags_reg[rd_ptr_reg];
    assign rd_data  = rd_data_reg;

    // buffer storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_ptr_reg, wr_idx}] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{rd_ptr_reg, rd_idx}];
        end
    end

    // descriptors
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cnt_reg[wr_ptr_reg]   <= push_cnt;
            flags_reg[wr_ptr_reg] <= push_flags;
        end
    end

    always_comb
    begin
        full_next   = full_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            full_next[wr_ptr_reg] = 1'b1;
            wr_ptr_next           = !wr_ptr_reg;
        end
        if (pop)
        begin
            full_next[rd_ptr_reg] = 1'b0;
            rd_ptr_next           = !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= 2'b00;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            full_reg   <= full_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    `GRK_ASSERT_NEVER(a_push_full, clk, rst_n, push && full_reg[wr_ptr_reg], "push into a full buffer")
    `GRK_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !full_reg[rd_ptr_reg], "pop of an empty buffer")
    `GRK_ASSERT_NEVER(a_wr_full, clk, rst_n, wr_en && full_reg[wr_ptr_reg], "write into a buffer being drained")

endmodule

// File: src/grk_front.sv
// Accepts elements, writes them into the open buffer and decides when a
// group is complete and how it drains.
module grk_front #(
    parameter int MAX_GROUP = 16,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [grk_pkg::GS_W-1:0]      group_size,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [grk_pkg::VAL_W-1:0]     value_in,
    input  logic                          end_of_list,
    input  logic                          wr_free,
    output logic                          wr_en,
    output logic [IW-1:0]                 wr_idx,
    output logic [grk_pkg::VAL_W-1:0]     wr_data,
    output logic                          push,
    output logic [CW-1:0]                 push_cnt,
    output grk_pkg::grk_flags_t           push_flags
);

    localparam int KW = (CW > grk_pkg::GS_W) ? CW : grk_pkg::GS_W;

    logic [grk_pkg::GS_W-1:0] gs_reg;
    logic [CW-1:0]            held_reg, held_next;
    logic [KW-1:0]            k_eff;
    logic [KW-1:0]            gs_ext;
    logic [CW-1:0]            n;
    logic                     full_grp;
    logic                     accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = wr_free;
    assign accept    = in_valid && in_ready;

    // zero acts as one, oversize clamps to MAX_GROUP
    assign gs_ext = KW'(gs_reg);
    always_comb
    begin
        if (gs_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (gs_ext > KW'(MAX_GROUP))
        begin
            k_eff = KW'(MAX_GROUP);
        end
        else
        begin
            k_eff = gs_ext;
        end
    end

    assign n        = held_reg + CW'(1);
    assign full_grp = KW'(n) >= k_eff;

    assign wr_en   = accept;
    assign wr_idx  = held_reg[IW-1:0];
    assign wr_data = value_in;

    assign push               = accept && (full_grp || end_of_list);
    assign push_cnt           = n;
    assign push_flags.reverse = full_grp;
    assign push_flags.last    = end_of_list;

    assign held_next = push ? '0 : (accept ? n : held_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg   <= grk_pkg::GS_W'(1);
            held_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                gs_reg <= group_size;
            end
            held_reg <= held_next;
        end
    end

endmodule

// File: src/grk_back.sv
`include "group_of_k_reverser_top_macros.svh"

// Drains finished groups, one element per cycle while out_ready does not stall,
// through the buffer read register and an output register.
module grk_back #(
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_valid,
    input  logic [CW-1:0]                 rd_cnt,
    input  grk_pkg::grk_flags_t           rd_flags,
    output logic                          rd_en,
    output logic [IW-1:0]                 rd_idx,
    input  logic [grk_pkg::VAL_W-1:0]     rd_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [grk_pkg::VAL_W-1:0] value_out,
    output logic                          last_out
);

    logic [IW-1:0]             idx_reg, idx_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_last_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [grk_pkg::VAL_W-1:0] out_value_reg;
    logic                      out_last_reg;
    logic [CW-1:0]             end_idx;
    logic [CW-1:0]             rev_idx;
    logic                      at_end;
    logic                      s1_move;
    logic                      issue;

    assign s1_move = !out_valid_reg || out_ready;
    assign issue   = rd_valid && (!s1_valid_reg || s1_move);

    assign end_idx = rd_cnt - CW'(1);
    assign rev_idx = end_idx - CW'(idx_reg);
    assign at_end  = CW'(idx_reg) == end_idx;

    assign rd_en  = issue;
    assign rd_idx = rd_flags.reverse ? rev_idx[IW-1:0] : idx_reg;
    assign pop    = issue && at_end;

    assign idx_next = pop ? '0 : (issue ? idx_reg + IW'(1) : idx_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign out_valid_next = (s1_valid_reg && s1_move) ? 1'b1 :
                            (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_last_reg <= rd_flags.last && at_end;
        end
        if (s1_valid_reg && s1_move)
        begin
            out_value_reg <= rd_data;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = out_value_reg;
    assign last_out  = out_last_reg;

    `GRK_ASSERT(a_idx_range, clk, rst_n, !rd_valid || (CW'(idx_reg) < rd_cnt), "drain index past group")
    `GRK_ASSERT(a_s1_hold, clk, rst_n, (s1_valid_reg && !s1_move) |=> s1_valid_reg, "read data dropped")
    `GRK_ASSERT_NEVER(a_issue_idle, clk, rst_n, rd_en && !rd_valid, "read with no group pending")

endmodule

// File: src/group_of_k_reverser_top.sv
// Channel  | handshake            | payload
// ---------+----------------------+---------------------------
// in       | in_valid / in_ready   | value_in, end_of_list
// out      | out_valid / out_ready | value_out, last_out
// cfg      | cfg_valid / cfg_ready | group_size (always ready)
//
// Flow: one element per cycle in while in_ready is high, one per cycle out
//   while out_ready does not stall; two group buffers overlap fill and drain.
//   A group's first result passes the buffer write, read and output registers.
// Input stalls only when both group buffers hold groups not yet drained.
// Reset: held count, buffer flags and output valid clear; buffer contents
//   are not cleared (only written entries are ever read). group_size = 1.
//
// Front end: counts the open group, writes each element into the open
// buffer and, when the group reaches the effective size or the sequence
// ends, hands the buffer over with its count and drain order. The effective
// size is group_size with zero read as one and large values clamped to
// MAX_GROUP. Back end: walks the handed-over buffer newest first (full
// group) or oldest first (short final group), one buffer read per cycle,
// with a read register and an output register so out_ready stalls hold
// without losing data.
module group_of_k_reverser_top #(
    parameter int MAX_GROUP = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [grk_pkg::GS_W-1:0]         group_size,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [grk_pkg::VAL_W-1:0] value_in,
    input  logic                             end_of_list,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [grk_pkg::VAL_W-1:0] value_out,
    output logic                             last_out
);

    // index into one buffer, and a count that can reach MAX_GROUP
    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);

    logic                      wr_free;
    logic                      wr_en;
    logic [IW-1:0]             wr_idx;
    logic [grk_pkg::VAL_W-1:0] wr_data;
    logic                      push;
    logic [CW-1:0]             push_cnt;
    grk_pkg::grk_flags_t       push_flags;
    logic                      rd_valid;
    logic [CW-1:0]             rd_cnt;
    grk_pkg::grk_flags_t       rd_flags;
    logic                      rd_en;
    logic [IW-1:0]             rd_idx;
    logic [grk_pkg::VAL_W-1:0] rd_data;
    logic                      pop;

    grk_front #(
        .MAX_GROUP (MAX_GROUP),
        .IW        (IW),
        .CW        (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .group_size  (group_size),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value_in    (value_in),
        .end_of_list (end_of_list),
        .wr_free     (wr_free),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .wr_data     (wr_data),
        .push        (push),
        .push_cnt    (push_cnt),
        .push_flags  (push_flags)
    );

    grk_queue #(
        .IW        (IW),
        .CW        (CW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_free    (wr_free),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data),
        .push       (push),
        .push_cnt   (push_cnt),
        .push_flags (push_flags),
        .rd_valid   (rd_valid),
        .rd_cnt     (rd_cnt),
        .rd_flags   (rd_flags),
        .rd_en      (rd_en),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data),
        .pop        (pop)
    );

    grk_back #(
        .IW (IW),
        .CW (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_valid  (rd_valid),
        .rd_cnt    (rd_cnt),
        .rd_flags  (rd_flags),
        .rd_en     (rd_en),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value_out (value_out),
        .last_out  (last_out)
    );

endmodule
